### rtl/jmss_pkg.sv
`default_nettype none
package jmss_pkg;

	localparam logic [7:0] BYTE_FF    = 8'hFF;
	localparam logic [7:0] MARKER_SOS = 8'hDA;
	localparam logic [7:0] MARKER_EOI = 8'hD9;
	localparam logic [15:0] MIN_SEG_LEN = 16'd2;

	typedef enum logic [3:0] {
		PH_LEAD0   = 4'd0,
		PH_LEAD1   = 4'd1,
		PH_HEADER  = 4'd2,
		PH_MARKER  = 4'd3,
		PH_LEN_HI  = 4'd4,
		PH_LEN_LO  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_ENTROPY = 4'd7,
		PH_ENT_FF  = 4'd8,
		PH_TRAIL   = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		CLS_LEAD    = 3'd0,
		CLS_PLAIN   = 3'd1,
		CLS_MARKER  = 3'd2,
		CLS_LENGTH  = 3'd3,
		CLS_PAYLOAD = 3'd4,
		CLS_ENTROPY = 3'd5,
		CLS_END     = 3'd6,
		CLS_COEFF   = 3'd7
	} cls_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] remaining_count;
		logic [7:0]  length_high;
		logic        scan_segment;
		logic [7:0]  low_coeff_byte;
		logic        coeff_half;
		logic        end_marker_seen;
	} state_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		cls_t               byte_class;
		logic               malformed_length;
		logic               coeff_valid;
		logic signed [15:0] coeff_value;
		logic               stream_done;
		logic               end_seen;
	} result_t;

	localparam state_t ST_RESET = '{
		phase:           PH_LEAD0,
		remaining_count: 16'd0,
		length_high:     8'd0,
		scan_segment:    1'b0,
		low_coeff_byte:  8'd0,
		coeff_half:      1'b0,
		end_marker_seen: 1'b0
	};

endpackage
`default_nettype wire

### rtl/jmss_step.sv
`default_nettype none
module jmss_step
	import jmss_pkg::*;
(
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	input  state_t     st,
	output state_t     st_next,
	output result_t    res
);

	logic [15:0] seg_len;
	logic        short_len;
	logic [15:0] len_rem;
	logic [15:0] pay_rem;
	phase_t      after_seg;
	logic        eoi_hit;

	assign seg_len   = {st.length_high, data_byte};
	assign short_len = seg_len < MIN_SEG_LEN;
	assign len_rem   = short_len ? 16'd0 : seg_len - MIN_SEG_LEN;
	assign pay_rem   = st.remaining_count - 16'd1;
	assign after_seg = st.scan_segment ? PH_ENTROPY : PH_HEADER;
	assign eoi_hit   = (st.phase == PH_ENT_FF) && (data_byte == MARKER_EOI);

	// Next state.
	always_comb begin
		st_next = st;
		unique case (st.phase)
			PH_LEAD0: st_next.phase = PH_LEAD1;
			PH_LEAD1: st_next.phase = PH_HEADER;
			PH_HEADER: begin
				if (data_byte == BYTE_FF)
					st_next.phase = PH_MARKER;
			end
			PH_MARKER: begin
				if (data_byte == MARKER_SOS)
					st_next.scan_segment = 1'b1;
				st_next.phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				st_next.length_high = data_byte;
				st_next.phase       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				st_next.remaining_count = len_rem;
				st_next.phase = (len_rem != 16'd0) ? PH_PAYLOAD : after_seg;
			end
			PH_PAYLOAD: begin
				st_next.remaining_count = pay_rem;
				if (pay_rem == 16'd0)
					st_next.phase = after_seg;
			end
			PH_ENTROPY: begin
				if (data_byte == BYTE_FF)
					st_next.phase = PH_ENT_FF;
			end
			PH_ENT_FF: begin
				if (eoi_hit) begin
					st_next.end_marker_seen = 1'b1;
					st_next.phase           = PH_TRAIL;
				end else begin
					st_next.phase = PH_ENTROPY;
				end
			end
			PH_TRAIL: begin
				if (st.coeff_half) begin
					st_next.coeff_half = 1'b0;
				end else begin
					st_next.low_coeff_byte = data_byte;
					st_next.coeff_half     = 1'b1;
				end
			end
			default: st_next.phase = PH_LEAD1;
		endcase
		// The final byte of a file leaves everything ready for a new file.
		if (end_of_file)
			st_next = ST_RESET;
	end

	// Result for this byte.
	always_comb begin
		res                  = '0;
		res.out_byte         = data_byte;
		res.byte_class       = CLS_PLAIN;
		res.stream_done      = end_of_file;
		res.end_seen         = st.end_marker_seen | eoi_hit;
		unique case (st.phase)
			PH_LEAD0:   res.byte_class = CLS_LEAD;
			PH_LEAD1:   res.byte_class = CLS_LEAD;
			PH_HEADER:  res.byte_class = CLS_PLAIN;
			PH_MARKER:  res.byte_class = CLS_MARKER;
			PH_LEN_HI:  res.byte_class = CLS_LENGTH;
			PH_LEN_LO: begin
				res.byte_class       = CLS_LENGTH;
				res.malformed_length = short_len;
			end
			PH_PAYLOAD: res.byte_class = CLS_PAYLOAD;
			PH_ENTROPY: res.byte_class = CLS_ENTROPY;
			PH_ENT_FF:  res.byte_class = eoi_hit ? CLS_END : CLS_ENTROPY;
			PH_TRAIL: begin
				res.byte_class = CLS_COEFF;
				if (st.coeff_half) begin
					res.coeff_valid = 1'b1;
					res.coeff_value = {data_byte, st.low_coeff_byte};
				end
			end
			default:    res.byte_class = CLS_LEAD;
		endcase
	end

endmodule
`default_nettype wire

### rtl/jpeg_marker_segment_scanner.sv
// JPEG marker segment scanner.
// The slave channel takes one file byte per request: s_tdata carries the byte,
// s_tlast marks the final byte of a file. The master channel returns exactly
// one result per byte, in order, carrying the byte back with its role in the
// file (leading pair, header, marker code, length, payload, entropy data, end
// marker, trailing coefficient) and the coefficient once a trailing pair is
// complete. m_tlast is set on the result for the final byte.
// An accepted byte reaches the master side through one input register, the
// byte-wise parse logic and one result register. Throughput is one byte per
// cycle while the receiver keeps up; the parse state is updated in the same
// cycle a byte moves from the input register into the result register.
// When the receiver stalls, the result register holds, the input register
// still takes one more byte, and s_tready drops only once both are full.
// Reset clears both registers and puts the parser at the first byte of the
// leading pair. After the final byte of a file the parser returns to that
// same state, so the next byte starts a new file.
`default_nettype none
module jpeg_marker_segment_scanner
	import jmss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] out_byte, [23:8] coeff_value, [24] end_seen
	output logic [4:0]  m_tuser,  // [2:0] byte_class, [3] malformed_length, [4] coeff_valid
	output logic        m_tlast   // stream_done
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       valid_s2;
	result_t    res_s2;
	state_t     st_q;
	state_t     st_next;
	result_t    res;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	jmss_step u_step (
		.data_byte   (data_s1),
		.end_of_file (last_s1),
		.st          (st_q),
		.st_next     (st_next),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			st_q     <= ST_RESET;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.end_seen, res_s2.coeff_value, res_s2.out_byte};
	assign m_tuser  = {res_s2.coeff_valid, res_s2.malformed_length, res_s2.byte_class};
	assign m_tlast  = res_s2.stream_done;

	// The final byte of a file puts the parser back at the leading pair.
	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> st_q.phase == PH_LEAD0 && !st_q.end_marker_seen)
		else $error("parser not restarted after final byte");

	// An empty result register never blocks the input side.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with result register empty");

	// A coefficient completes only on the second byte of a pair.
	a_coeff_pair: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.coeff_valid |-> st_q.coeff_half && st_q.phase == PH_TRAIL)
		else $error("coefficient without a stored low byte");

	// The end marker reports end_seen and starts the trailer unless the file ends.
	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.byte_class == CLS_END |-> res.end_seen && st_next.phase == PH_TRAIL
			|| last_s1)
		else $error("end marker not recorded");

endmodule
`default_nettype wire

### sim/jpeg_marker_segment_scanner_tb.sv
`default_nettype none
module jpeg_marker_segment_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jmss_pkg::*;

	class scan_scoreboard;
		phase_t      scan_phase;
		logic [15:0] bytes_left;
		logic [7:0]  len_high_byte;
		logic        in_scan;
		logic [7:0]  coeff_low_byte;
		logic        coeff_pending;
		logic        eoi_seen;

		result_t     expected_q[$];
		int          errors;
		int          files;
		int          results_checked;
		int          coeffs;
		int          short_lengths;
		int          end_markers;

		function new();
			clear_state();
			errors = 0;
			files = 0;
			results_checked = 0;
			coeffs = 0;
			short_lengths = 0;
			end_markers = 0;
		endfunction

		function void clear_state();
			scan_phase = PH_LEAD0;
			bytes_left = '0;
			len_high_byte = '0;
			in_scan = 1'b0;
			coeff_low_byte = '0;
			coeff_pending = 1'b0;
			eoi_seen = 1'b0;
		endfunction

		function phase_t after_segment();
			return in_scan ? PH_ENTROPY : PH_HEADER;
		endfunction

		// Works out the result for one accepted byte and advances the parse state.
		function void note_byte(logic [7:0] b, logic last);
			result_t     r;
			logic [15:0] seg_len;
			r = '0;
			r.out_byte = b;
			r.byte_class = CLS_PLAIN;
			r.stream_done = last;
			case (scan_phase)
				PH_LEAD1: begin
					r.byte_class = CLS_LEAD;
					scan_phase = PH_HEADER;
				end
				PH_HEADER: begin
					if (b == BYTE_FF)
						scan_phase = PH_MARKER;
				end
				PH_MARKER: begin
					r.byte_class = CLS_MARKER;
					if (b == MARKER_SOS)
						in_scan = 1'b1;
					scan_phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					r.byte_class = CLS_LENGTH;
					len_high_byte = b;
					scan_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					r.byte_class = CLS_LENGTH;
					seg_len = {len_high_byte, b};
					if (seg_len < MIN_SEG_LEN) begin
						r.malformed_length = 1'b1;
						bytes_left = '0;
						short_lengths++;
					end else begin
						bytes_left = seg_len - MIN_SEG_LEN;
					end
					scan_phase = (bytes_left != 0) ? PH_PAYLOAD : after_segment();
				end
				PH_PAYLOAD: begin
					r.byte_class = CLS_PAYLOAD;
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 0)
						scan_phase = after_segment();
				end
				PH_ENTROPY: begin
					r.byte_class = CLS_ENTROPY;
					if (b == BYTE_FF)
						scan_phase = PH_ENT_FF;
				end
				PH_ENT_FF: begin
					if (b == MARKER_EOI) begin
						r.byte_class = CLS_END;
						eoi_seen = 1'b1;
						scan_phase = PH_TRAIL;
						end_markers++;
					end else begin
						r.byte_class = CLS_ENTROPY;
						scan_phase = PH_ENTROPY;
					end
				end
				PH_TRAIL: begin
					r.byte_class = CLS_COEFF;
					if (coeff_pending) begin
						r.coeff_valid = 1'b1;
						r.coeff_value = {b, coeff_low_byte};
						coeff_pending = 1'b0;
						coeffs++;
					end else begin
						coeff_low_byte = b;
						coeff_pending = 1'b1;
					end
				end
				default: begin
					r.byte_class = CLS_LEAD;
					scan_phase = PH_LEAD1;
				end
			endcase
			r.end_seen = eoi_seen;
			expected_q = {expected_q, r};
			if (last) begin
				clear_state();
				files++;
			end
		endfunction

		function bit field_ok(string name, longint exp_val, longint act_val);
			if (exp_val != act_val) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
					act_val);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(logic [31:0] tdata, logic [4:0] tuser, logic tlast);
			result_t r;
			bit      ok;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual tdata %h tuser %h tlast %b",
					$time, tdata, tuser, tlast);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			results_checked++;
			ok = 1'b1;
			ok &= field_ok("out_byte", r.out_byte, tdata[7:0]);
			ok &= field_ok("byte_class", r.byte_class, tuser[2:0]);
			ok &= field_ok("malformed_length", r.malformed_length, tuser[3]);
			ok &= field_ok("coeff_valid", r.coeff_valid, tuser[4]);
			ok &= field_ok("coeff_value", r.coeff_value, $signed(tdata[23:8]));
			ok &= field_ok("stream_done", r.stream_done, tlast);
			ok &= field_ok("end_seen", r.end_seen, tdata[24]);
			if (!ok)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // [7:0] out_byte, [23:8] coeff_value, [24] end_seen
	logic [4:0]  m_tuser;  // [2:0] byte_class, [3] malformed_length, [4] coeff_valid
	logic        m_tlast;  // stream_done

	scan_scoreboard sb = new();

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_cycles = 0;
	int          bytes_sent = 0;
	logic [7:0]  file_q[$];

	jpeg_marker_segment_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", sb.expected_q.size());
		$display("Some tests failed");
		$finish;
	end

	// Receiver: a long hold-off, when requested, takes priority over random stalls.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	function automatic void append_byte(input logic [7:0] b);
		file_q = {file_q, b};
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b, last);
	endtask

	task automatic send_file(input int n);
		for (int i = 0; i < n; i++)
			send_byte(file_q[i], i == n - 1);
		bytes_sent += n;
	endtask

	// Mostly well-formed files with random content, some cut short, some pure noise.
	task automatic build_file(output int n_send);
		int          kind;
		int          n;
		int          plen;
		logic [15:0] seg_len;
		logic [7:0]  mk;
		file_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(1, 24);
			repeat (n) append_byte(8'($urandom));
			n_send = n;
			return;
		end
		if ($urandom_range(0, 9) < 7) begin
			append_byte(BYTE_FF);
			append_byte(8'hD8);
		end else begin
			append_byte(8'($urandom));
			append_byte(8'($urandom));
		end
		repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 254)));
		repeat ($urandom_range(0, 3)) begin
			append_byte(BYTE_FF);
			mk = 8'($urandom);
			if (mk == MARKER_SOS)
				mk = 8'hC4;
			append_byte(mk);
			case ($urandom_range(0, 19))
				0: seg_len = 16'd0;
				1: seg_len = 16'd1;
				2: begin
					// A long segment is only started; the file ends inside its payload.
					seg_len = 16'($urandom_range(256, 65535));
					append_byte(seg_len[15:8]);
					append_byte(seg_len[7:0]);
					repeat ($urandom_range(0, 5)) append_byte(8'($urandom));
					n_send = file_q.size();
					return;
				end
				default: seg_len = 16'($urandom_range(2, 9));
			endcase
			append_byte(seg_len[15:8]);
			append_byte(seg_len[7:0]);
			plen = (seg_len >= MIN_SEG_LEN) ? int'(seg_len) - 2 : 0;
			repeat (plen) append_byte(8'($urandom));
			repeat ($urandom_range(0, 1)) append_byte(8'($urandom_range(0, 254)));
		end
		append_byte(BYTE_FF);
		append_byte(MARKER_SOS);
		seg_len = 16'($urandom_range(2, 8));
		append_byte(seg_len[15:8]);
		append_byte(seg_len[7:0]);
		repeat (int'(seg_len) - 2) append_byte(8'($urandom));
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 6) == 0) begin
				append_byte(BYTE_FF);
				mk = 8'($urandom);
				if (mk == MARKER_EOI)
					mk = BYTE_FF;
				append_byte(mk);
			end else begin
				append_byte(8'($urandom_range(0, 254)));
			end
		end
		append_byte(BYTE_FF);
		append_byte(MARKER_EOI);
		repeat ($urandom_range(0, 9)) append_byte(8'($urandom));
		n_send = file_q.size();
		if (kind < 25)
			n_send = $urandom_range(1, n_send);
	endtask

	task automatic run_random(input int quota);
		int sent_here;
		int n;
		sent_here = 0;
		while (sent_here < quota) begin
			build_file(n);
			send_file(n);
			sent_here += n;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Header marker D9, both short lengths, a one-byte scan payload, entropy escapes,
		// the end marker, extreme coefficients and an odd trailing byte.
		file_q = '{8'hFF, 8'hD8, 8'h00, 8'hFF, 8'hD9, 8'h00, 8'h01, 8'hFF, 8'hC0, 8'h00,
			8'h00, 8'hFF, 8'hDA, 8'h00, 8'h03, 8'h7F, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			8'hD9, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hAB};
		send_file(file_q.size());

		// The receiver holds off while the sender keeps offering bytes.
		hold_cycles = 400;
		run_random(350);

		send_idle_pct = 87;
		recv_stall_pct = 0;
		run_random(350);

		send_idle_pct = 0;
		recv_stall_pct = 87;
		run_random(350);

		send_idle_pct = 35;
		recv_stall_pct = 35;
		run_random(350);

		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Scanned %0d bytes in %0d complete files, %0d results checked",
			bytes_sent, sb.files, sb.results_checked);
		$display("Seen %0d coefficients, %0d short lengths, %0d end markers, under four idle mixes",
			sb.coeffs, sb.short_lengths, sb.end_markers);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

### jpeg_marker_segment_scanner.f
rtl/jmss_pkg.sv
rtl/jmss_step.sv
rtl/jpeg_marker_segment_scanner.sv
sim/jpeg_marker_segment_scanner_tb.sv
